// File: rtl/bfda_pkg.sv
// ----------------------------------------------------------------------------
// bfda_pkg
// Shared types, codes and defaults for the best-fit descriptor allocator.
// ----------------------------------------------------------------------------
package bfda_pkg;

   // Default free-list depth
   localparam int FREE_LIST_DEPTH_DEF = 64;

   // Field widths
   localparam int HANDLE_W = 64;
   localparam int SIZE_W   = 21;
   localparam int STRIDE_W = 13;
   localparam int STATUS_W = 3;
   localparam int OFFSET_W = SIZE_W + STRIDE_W;

   // Register reset values
   localparam logic [STRIDE_W-1:0] STRIDE_RST   = STRIDE_W'(32);
   localparam logic [SIZE_W-1:0]   CAPACITY_RST = SIZE_W'(1048576);

   // Register indexes (byte address bits [4:3])
   localparam logic [1:0] REG_CPU_BASE = 2'd0;
   localparam logic [1:0] REG_GPU_BASE = 2'd1;
   localparam logic [1:0] REG_STRIDE   = 2'd2;
   localparam logic [1:0] REG_CAPACITY = 2'd3;

   // Operation codes
   localparam logic OP_GET     = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_EXACT     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BEST      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FRESH     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd5;

   // One free-list entry as stored in the list memory
   typedef struct packed {
      logic [HANDLE_W-1:0] cpu_hdl;
      logic [HANDLE_W-1:0] gpu_hdl;
      logic [SIZE_W-1:0]   size;
   } entry_type;

endpackage

// File: rtl/bfda_ram.sv
// ----------------------------------------------------------------------------
// bfda_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module bfda_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: rtl/best_fit_descriptor_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_descriptor_allocator
// Hands out descriptor ranges: exact or best-fit reuse from a free list,
// else fresh ranges cut from the heap at a bump index; releases append to the list.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_* and raise start; the transaction is taken at
//   a rising edge with start high and busy low. busy stays high until the
//   result is issued. req_opcode selects get or release.
//   Result channel: one result per transaction, shown for one cycle with
//   rsp_strobe high. The receiver cannot stall it and must take it then.
//   Configuration: APB-style port, 64-bit registers at byte addresses 0, 8,
//   16 and 24 (CPU base, GPU base, stride, capacity); pready is always high.
//   Write registers only while busy is low.
// Sequence, from the accept edge through the strobe cycle:
//   release: append or drop, then the strobe cycle.
//   get with reuse: list scan, one entry per cycle through the single read
//   port of the list memory and ending early on an exact hit, then
//   compaction of the later entries and the strobe cycle.
//   get with fresh grant or exhaustion: scan, then the heap room check and,
//   for a fresh grant, the offset add before the strobe cycle.
//   A new transaction may be accepted in the cycle the strobe is high.
// Reset: list empty, bump index zero, registers at their defaults. The list
//   memory is not cleared; only entries below the fill count are read.
// ----------------------------------------------------------------------------
module best_fit_descriptor_allocator #(
   parameter int FREE_LIST_DEPTH = bfda_pkg::FREE_LIST_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   // Request channel
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_opcode,
   input  logic [bfda_pkg::SIZE_W-1:0]         req_range_size,
   input  logic [bfda_pkg::HANDLE_W-1:0]       req_release_cpu_handle,
   input  logic [bfda_pkg::HANDLE_W-1:0]       req_release_gpu_handle,

   // Result channel
   output logic                                rsp_strobe,
   output logic [bfda_pkg::HANDLE_W-1:0]       rsp_granted_cpu_handle,
   output logic [bfda_pkg::HANDLE_W-1:0]       rsp_granted_gpu_handle,
   output logic [bfda_pkg::SIZE_W-1:0]         rsp_granted_size,
   output logic [bfda_pkg::STATUS_W-1:0]       rsp_status,

   // Configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [4:0]                          paddr,
   input  logic [63:0]                         pwdata,
   output logic [63:0]                         prdata,
   output logic                                pready
);

   localparam int ADDR_W  = $clog2(FREE_LIST_DEPTH);
   localparam int CNT_W   = $clog2(FREE_LIST_DEPTH + 1);
   localparam int ENTRY_W = $bits(bfda_pkg::entry_type);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RELEASE,
      S_SCAN,
      S_SHIFT,
      S_FRESH_CHK,
      S_FRESH_ADD
   } state_type;

   // Configuration registers
   logic [bfda_pkg::HANDLE_W-1:0] cpu_base_ff;
   logic [bfda_pkg::HANDLE_W-1:0] gpu_base_ff;
   logic [bfda_pkg::STRIDE_W-1:0] stride_ff;
   logic [bfda_pkg::SIZE_W-1:0]   capacity_ff;

   // Sequencer state and registers
   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [bfda_pkg::SIZE_W-1:0]   next_fresh_ff, next_fresh_in;
   logic [CNT_W-1:0]              rd_ptr_ff, rd_ptr_in;
   logic                          pend_ff, pend_in;
   logic [ADDR_W-1:0]             cmp_idx_ff, cmp_idx_in;
   logic                          have_best_ff, have_best_in;
   logic [ADDR_W-1:0]             best_idx_ff, best_idx_in;
   bfda_pkg::entry_type           best_entry_ff, best_entry_in;
   logic [bfda_pkg::STATUS_W-1:0] take_status_ff, take_status_in;
   logic [bfda_pkg::SIZE_W-1:0]   req_size_ff, req_size_in;
   logic [bfda_pkg::HANDLE_W-1:0] req_cpu_ff, req_cpu_in;
   logic [bfda_pkg::HANDLE_W-1:0] req_gpu_ff, req_gpu_in;
   logic [bfda_pkg::OFFSET_W-1:0] offset_ff, offset_in;

   // Result registers
   logic                          strobe_ff, strobe_in;
   logic [bfda_pkg::HANDLE_W-1:0] out_cpu_ff, out_cpu_in;
   logic [bfda_pkg::HANDLE_W-1:0] out_gpu_ff, out_gpu_in;
   logic [bfda_pkg::SIZE_W-1:0]   out_size_ff, out_size_in;
   logic [bfda_pkg::STATUS_W-1:0] out_status_ff, out_status_in;

   // List memory ports
   logic                          ram_wr_en;
   logic [ADDR_W-1:0]             ram_wr_addr;
   logic [ENTRY_W-1:0]            ram_wr_data;
   logic [ADDR_W-1:0]             ram_rd_addr;
   logic [ENTRY_W-1:0]            ram_rd_data;
   bfda_pkg::entry_type           rd_entry;

   // Shared compare unit and helpers
   logic                          cmp_eq;
   logic                          cmp_gt;
   logic                          cmp_lt_best;
   logic                          issue;
   logic                          accept;
   logic                          cfg_wr;
   logic [bfda_pkg::SIZE_W:0]     fresh_end;
   bfda_pkg::entry_type           rel_entry;

   bfda_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (FREE_LIST_DEPTH)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry    = bfda_pkg::entry_type'(ram_rd_data);
   assign cmp_eq      = (rd_entry.size == req_size_ff);
   assign cmp_gt      = (rd_entry.size > req_size_ff);
   assign cmp_lt_best = (rd_entry.size < best_entry_ff.size);
   assign issue       = (rd_ptr_ff < count_ff);
   assign accept      = start && !busy;
   assign cfg_wr      = psel && penable && pwrite;
   assign fresh_end   = {1'b0, next_fresh_ff} + {1'b0, req_size_ff};

   assign rel_entry.cpu_hdl = req_cpu_ff;
   assign rel_entry.gpu_hdl = req_gpu_ff;
   assign rel_entry.size    = req_size_ff;

   // Drive list memory: append on release, move down during compaction
   always_comb begin
      ram_rd_addr = rd_ptr_ff[ADDR_W-1:0];
      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[ADDR_W-1:0];
      ram_wr_data = ENTRY_W'(rel_entry);
      if (state_ff == S_RELEASE) begin
         ram_wr_en = (count_ff < CNT_W'(FREE_LIST_DEPTH));
      end else if (state_ff == S_SHIFT) begin
         ram_wr_en   = pend_ff;
         ram_wr_addr = cmp_idx_ff - ADDR_W'(1);
         ram_wr_data = ram_rd_data;
      end
   end

   // Sequence one transaction
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      next_fresh_in  = next_fresh_ff;
      rd_ptr_in      = rd_ptr_ff;
      pend_in        = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      have_best_in   = have_best_ff;
      best_idx_in    = best_idx_ff;
      best_entry_in  = best_entry_ff;
      take_status_in = take_status_ff;
      req_size_in    = req_size_ff;
      req_cpu_in     = req_cpu_ff;
      req_gpu_in     = req_gpu_ff;
      offset_in      = offset_ff;
      strobe_in      = 1'b0;
      out_cpu_in     = out_cpu_ff;
      out_gpu_in     = out_gpu_ff;
      out_size_in    = out_size_ff;
      out_status_in  = out_status_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_size_in  = req_range_size;
               req_cpu_in   = req_release_cpu_handle;
               req_gpu_in   = req_release_gpu_handle;
               rd_ptr_in    = '0;
               have_best_in = 1'b0;
               state_in     = (req_opcode == bfda_pkg::OP_RELEASE) ? S_RELEASE : S_SCAN;
            end
         end

         S_RELEASE: begin
            // Append if there is room, else drop
            strobe_in   = 1'b1;
            out_cpu_in  = '0;
            out_gpu_in  = '0;
            out_size_in = '0;
            if (count_ff < CNT_W'(FREE_LIST_DEPTH)) begin
               count_in      = count_ff + CNT_W'(1);
               out_status_in = bfda_pkg::ST_RELEASED;
            end else begin
               out_status_in = bfda_pkg::ST_DROPPED;
            end
            state_in = S_IDLE;
         end

         S_SCAN: begin
            // Issue one read per cycle, compare the entry read last cycle
            if (issue) begin
               rd_ptr_in  = rd_ptr_ff + CNT_W'(1);
               pend_in    = 1'b1;
               cmp_idx_in = rd_ptr_ff[ADDR_W-1:0];
            end
            if (pend_ff && cmp_eq) begin
               best_idx_in    = cmp_idx_ff;
               best_entry_in  = rd_entry;
               take_status_in = bfda_pkg::ST_EXACT;
               rd_ptr_in      = CNT_W'(cmp_idx_ff) + CNT_W'(1);
               pend_in        = 1'b0;
               state_in       = S_SHIFT;
            end else if (pend_ff && cmp_gt && (!have_best_ff || cmp_lt_best)) begin
               have_best_in  = 1'b1;
               best_idx_in   = cmp_idx_ff;
               best_entry_in = rd_entry;
            end else if (!pend_ff && !issue) begin
               if (have_best_ff) begin
                  take_status_in = bfda_pkg::ST_BEST;
                  rd_ptr_in      = CNT_W'(best_idx_ff) + CNT_W'(1);
                  state_in       = S_SHIFT;
               end else begin
                  state_in = S_FRESH_CHK;
               end
            end
         end

         S_SHIFT: begin
            // Move each later entry down by one, then shrink the list
            if (issue) begin
               rd_ptr_in  = rd_ptr_ff + CNT_W'(1);
               pend_in    = 1'b1;
               cmp_idx_in = rd_ptr_ff[ADDR_W-1:0];
            end else begin
               count_in      = count_ff - CNT_W'(1);
               strobe_in     = 1'b1;
               out_cpu_in    = best_entry_ff.cpu_hdl;
               out_gpu_in    = best_entry_ff.gpu_hdl;
               out_size_in   = best_entry_ff.size;
               out_status_in = take_status_ff;
               state_in      = S_IDLE;
            end
         end

         S_FRESH_CHK: begin
            // Check heap room and form the byte offset
            offset_in = bfda_pkg::OFFSET_W'(next_fresh_ff) * bfda_pkg::OFFSET_W'(stride_ff);
            if (fresh_end > {1'b0, capacity_ff}) begin
               strobe_in     = 1'b1;
               out_cpu_in    = '0;
               out_gpu_in    = '0;
               out_size_in   = '0;
               out_status_in = bfda_pkg::ST_EXHAUSTED;
               state_in      = S_IDLE;
            end else begin
               state_in = S_FRESH_ADD;
            end
         end

         S_FRESH_ADD: begin
            // Add offset to both bases and bump the index
            strobe_in     = 1'b1;
            out_cpu_in    = cpu_base_ff + bfda_pkg::HANDLE_W'(offset_ff);
            out_gpu_in    = gpu_base_ff + bfda_pkg::HANDLE_W'(offset_ff);
            out_size_in   = req_size_ff;
            out_status_in = bfda_pkg::ST_FRESH;
            next_fresh_in = fresh_end[bfda_pkg::SIZE_W-1:0];
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state, configuration and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         next_fresh_ff <= '0;
         pend_ff       <= 1'b0;
         have_best_ff  <= 1'b0;
         strobe_ff     <= 1'b0;
         cpu_base_ff   <= '0;
         gpu_base_ff   <= '0;
         stride_ff     <= bfda_pkg::STRIDE_RST;
         capacity_ff   <= bfda_pkg::CAPACITY_RST;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         next_fresh_ff <= next_fresh_in;
         pend_ff       <= pend_in;
         have_best_ff  <= have_best_in;
         strobe_ff     <= strobe_in;
         if (cfg_wr) begin
            case (paddr[4:3])
               bfda_pkg::REG_CPU_BASE: cpu_base_ff <= pwdata;
               bfda_pkg::REG_GPU_BASE: gpu_base_ff <= pwdata;
               bfda_pkg::REG_STRIDE:   stride_ff   <= pwdata[bfda_pkg::STRIDE_W-1:0];
               bfda_pkg::REG_CAPACITY: capacity_ff <= pwdata[bfda_pkg::SIZE_W-1:0];
               default: ;
            endcase
         end
      end
      rd_ptr_ff      <= rd_ptr_in;
      cmp_idx_ff     <= cmp_idx_in;
      best_idx_ff    <= best_idx_in;
      best_entry_ff  <= best_entry_in;
      take_status_ff <= take_status_in;
      req_size_ff    <= req_size_in;
      req_cpu_ff     <= req_cpu_in;
      req_gpu_ff     <= req_gpu_in;
      offset_ff      <= offset_in;
      out_cpu_ff     <= out_cpu_in;
      out_gpu_ff     <= out_gpu_in;
      out_size_ff    <= out_size_in;
      out_status_ff  <= out_status_in;
   end

   // Register read-back
   always_comb begin
      case (paddr[4:3])
         bfda_pkg::REG_CPU_BASE: prdata = cpu_base_ff;
         bfda_pkg::REG_GPU_BASE: prdata = gpu_base_ff;
         bfda_pkg::REG_STRIDE:   prdata = 64'(stride_ff);
         bfda_pkg::REG_CAPACITY: prdata = 64'(capacity_ff);
         default:                prdata = '0;
      endcase
   end

   assign pready                 = 1'b1;
   assign busy                   = (state_ff != S_IDLE);
   assign rsp_strobe             = strobe_ff;
   assign rsp_granted_cpu_handle = out_cpu_ff;
   assign rsp_granted_gpu_handle = out_gpu_ff;
   assign rsp_granted_size       = out_size_ff;
   assign rsp_status             = out_status_ff;

   // A result is only issued once the sequencer is back to idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result issued while busy");

   // Every accepted transaction occupies the sequencer
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not start the sequencer");

   // List fill never exceeds its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FREE_LIST_DEPTH))
      else $error("free list count overflow");

   // Release results carry no range
   a_release_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == bfda_pkg::ST_RELEASED ||
                      rsp_status == bfda_pkg::ST_DROPPED))
      |-> (rsp_granted_size == '0 && rsp_granted_cpu_handle == '0))
      else $error("release result carries a range");

   // A fresh grant advances the bump index by the granted size
   a_fresh_bump: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == bfda_pkg::ST_FRESH) |->
      (next_fresh_ff == bfda_pkg::SIZE_W'($past(next_fresh_ff) + rsp_granted_size)))
      else $error("bump index not advanced by fresh grant");

endmodule
